### hdl/jtn_pkg.sv
package jtn_pkg;

  localparam int CpW = 21;
  typedef logic [CpW-1:0] cp_t;

  // code points with special handling
  localparam cp_t VuFull   = 21'h030F4;
  localparam cp_t HkFirst  = 21'h0FF61;
  localparam cp_t HkLast   = 21'h0FF9F;
  localparam cp_t HkU      = 21'h0FF73;
  localparam cp_t MarkV    = 21'h0FF9E;
  localparam cp_t MarkSv   = 21'h0FF9F;
  localparam cp_t HiraLo   = 21'h03041;
  localparam cp_t HiraHi   = 21'h03093;
  localparam cp_t KataLo   = 21'h030A1;
  localparam cp_t KataHi   = 21'h030F3;
  localparam cp_t FwDigit0 = 21'h0FF10;
  localparam cp_t AsciiD0  = 21'h00030;
  localparam cp_t AsciiLa  = 21'h00061;

  // row of the pending store that holds both lookahead characters
  localparam int PendDepth = 2;
  localparam logic [0:0] PendRow = 1'b0;

  typedef struct packed {
    cp_t  cp;
    logic last;
  } res_t;

  // outcome of one input transaction
  typedef struct packed {
    logic [1:0] res_n;
    res_t       res0;
    res_t       res1;
    logic [1:0] pend_n;
    cp_t        pend0;
    cp_t        pend1;
  } step_t;

  // plain fullwidth target of halfwidth forms, zero means pass through
  function automatic logic [15:0] hk_base(input logic [5:0] idx);
    logic [15:0] v;
    case (idx)
      6'd0:  v = 16'hFF0E; 6'd3:  v = 16'hFF0C; 6'd5:  v = 16'h30AA;
      6'd6:  v = 16'h30A2; 6'd7:  v = 16'h30A4; 6'd8:  v = 16'h30A6;
      6'd9:  v = 16'h30A8; 6'd10: v = 16'h30AA; 6'd11: v = 16'h30E4;
      6'd12: v = 16'h30E6; 6'd13: v = 16'h30E8; 6'd14: v = 16'h30C4;
      6'd15: v = 16'h30FC; 6'd16: v = 16'h30A2; 6'd17: v = 16'h30A4;
      6'd18: v = 16'h30A6; 6'd19: v = 16'h30A8; 6'd20: v = 16'h30AA;
      6'd21: v = 16'h30AB; 6'd22: v = 16'h30AD; 6'd23: v = 16'h30AF;
      6'd24: v = 16'h30B1; 6'd25: v = 16'h30B3; 6'd26: v = 16'h30B5;
      6'd27: v = 16'h30B7; 6'd28: v = 16'h30B9; 6'd29: v = 16'h30BB;
      6'd30: v = 16'h30BD; 6'd31: v = 16'h30BF; 6'd32: v = 16'h30C1;
      6'd33: v = 16'h30C4; 6'd34: v = 16'h30C6; 6'd35: v = 16'h30C8;
      6'd36: v = 16'h30CA; 6'd37: v = 16'h30CB; 6'd38: v = 16'h30CC;
      6'd39: v = 16'h30CD; 6'd40: v = 16'h30CE; 6'd41: v = 16'h30CF;
      6'd42: v = 16'h30D2; 6'd43: v = 16'h30D5; 6'd44: v = 16'h30D8;
      6'd45: v = 16'h30DB; 6'd46: v = 16'h30DE; 6'd47: v = 16'h30DF;
      6'd48: v = 16'h30E0; 6'd49: v = 16'h30E1; 6'd50: v = 16'h30E2;
      6'd51: v = 16'h30E4; 6'd52: v = 16'h30E6; 6'd53: v = 16'h30E8;
      6'd54: v = 16'h30E9; 6'd55: v = 16'h30EA; 6'd56: v = 16'h30EB;
      6'd57: v = 16'h30EC; 6'd58: v = 16'h30ED; 6'd59: v = 16'h30EF;
      6'd60: v = 16'h30F3;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

  function automatic logic [5:0] hk_idx(input cp_t c);
    cp_t d;
    d = c - HkFirst;
    return d[5:0];
  endfunction

  function automatic logic hk_range(input cp_t c);
    return (c >= HkFirst) && (c <= HkLast);
  endfunction

  function automatic cp_t hk_plain(input cp_t c);
    logic [15:0] v;
    v = hk_base(hk_idx(c));
    return (v != 16'h0000) ? {5'd0, v} : c;
  endfunction

  function automatic logic hk_listed(input cp_t c);
    return hk_range(c) && (hk_base(hk_idx(c)) != 16'h0000);
  endfunction

  // characters that wait for the next one before they resolve
  function automatic logic is_holder(input cp_t c);
    return (c == VuFull) || (c == HkU) || hk_listed(c);
  endfunction

  function automatic cp_t hk_marked(input cp_t c, input cp_t mark);
    cp_t  v;
    logic dak;
    logic han;
    v   = hk_plain(c);
    han = (c >= 21'h0FF8A) && (c <= 21'h0FF8E);
    dak = ((c >= 21'h0FF76) && (c <= 21'h0FF84)) || han;
    if ((mark == MarkV) && dak) begin
      v = v + 21'd1;
    end else if ((mark == MarkSv) && han) begin
      v = v + 21'd2;
    end
    return v;
  endfunction

  function automatic cp_t fold_hira(input cp_t c);
    cp_t v;
    if (c <= 21'h03049) begin
      v = (c[0] ? c + 21'd1 : c) + 21'h60;
    end else begin
      case (c)
        21'h03063: v = 21'h030C4;
        21'h03083, 21'h03085, 21'h03087: v = c + 21'h61;
        21'h0308E: v = c;
        21'h03090: v = 21'h030A4;
        21'h03091: v = 21'h030A8;
        21'h03092: v = 21'h030AA;
        default:   v = c + 21'h60;
      endcase
    end
    return v;
  endfunction

  function automatic cp_t fold_kata(input cp_t c);
    cp_t v;
    if ((c <= 21'h030A9) && c[0]) begin
      v = c + 21'd1;
    end else begin
      case (c)
        21'h030C3, 21'h030E3, 21'h030E5, 21'h030E7: v = c + 21'd1;
        21'h030F0: v = 21'h030A4;
        21'h030F1: v = 21'h030A8;
        21'h030F2: v = 21'h030AA;
        default:   v = c;
      endcase
    end
    return v;
  endfunction

  function automatic cp_t sym_map(input cp_t c);
    cp_t v;
    case (c)
      21'h03000: v = 21'h20; 21'h0FF01: v = 21'h21; 21'h0201D: v = 21'h22;
      21'h0FF03: v = 21'h23; 21'h0FF04: v = 21'h24; 21'h0FF05: v = 21'h25;
      21'h0FF06: v = 21'h26; 21'h02019: v = 21'h27; 21'h0FF08: v = 21'h28;
      21'h0FF09: v = 21'h29; 21'h0FF5B: v = 21'h7B; 21'h0FF5D: v = 21'h7D;
      21'h0FF3B: v = 21'h5B; 21'h0FF3D: v = 21'h5D; 21'h0FF1C: v = 21'h3C;
      21'h0FF1E: v = 21'h3E; 21'h0FF1D: v = 21'h3D; 21'h0FF0B: v = 21'h2B;
      21'h0FF0D: v = 21'h2D; 21'h0FF0A: v = 21'h2A; 21'h0FF0F: v = 21'h2F;
      21'h0FF3C: v = 21'h5C; 21'h0FF5C: v = 21'h7C; 21'h0FF3F: v = 21'h5F;
      21'h0FF20: v = 21'h40; 21'h0FF1A: v = 21'h3A; 21'h0FF1B: v = 21'h3B;
      21'h02018: v = 21'h60;
      default:   v = c;
    endcase
    return v;
  endfunction

  // mapping of a character on its own
  function automatic cp_t fold_one(input cp_t c);
    cp_t v;
    if ((c >= HiraLo) && (c <= HiraHi)) begin
      v = fold_hira(c);
    end else if ((c >= KataLo) && (c <= KataHi)) begin
      v = fold_kata(c);
    end else if (c == VuFull) begin
      v = 21'h030D6;
    end else if ((c >= FwDigit0) && (c <= 21'h0FF19)) begin
      v = c - FwDigit0 + AsciiD0;
    end else if ((c >= 21'h0FF21) && (c <= 21'h0FF3A)) begin
      v = c - 21'h0FF21 + AsciiLa;
    end else if ((c >= 21'h0FF41) && (c <= 21'h0FF5A)) begin
      v = c - 21'h0FF41 + AsciiLa;
    end else if ((c >= 21'h41) && (c <= 21'h5A)) begin
      v = c + 21'h20;
    end else if ((c >= AsciiLa) && (c <= 21'h7A)) begin
      v = c;
    end else if (hk_range(c)) begin
      v = hk_plain(c);
    end else begin
      v = sym_map(c);
    end
    return v;
  endfunction

endpackage

### hdl/jtn_if.sv
interface jtn_in_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        last_char;

  modport source (output valid, output code_point, output last_char, input ready);
  modport sink (input valid, input code_point, input last_char, output ready);
endinterface

interface jtn_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] out_code_point;
  logic        out_last;

  modport source (output valid, output out_code_point, output out_last, input ready);
  modport sink (input valid, input out_code_point, input out_last, output ready);
endinterface

### hdl/japanese_text_normalizer.sv
// channel  dir  payload                      transaction
// in_i     in   code_point, last_char        valid && ready
// out_o    out  out_code_point, out_last     valid && ready
//
// one input character per cycle while the queue has room; a character yields zero, one or two results
// results pass a four-entry queue, so input stalls while fewer than two slots are free
// lookahead characters live in a ram with a registered read, bypassed after a write
// reset clears the pending count and the queue; the ram needs no clearing
// sustained rate is set by the output port: one result per cycle while out_o.ready is high
module japanese_text_normalizer import jtn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  jtn_in_if.sink    in_i,
  jtn_out_if.source out_o
);

  logic          in_acc;
  logic          room;
  logic [1:0]    pend_cnt_q;
  logic          fwd_q;
  logic [2*CpW-1:0] fwd_data_q;
  logic [2*CpW-1:0] ram_rdata;
  logic [2*CpW-1:0] pend_row;
  cp_t           pend0;
  cp_t           pend1;
  step_t         step;

  assign in_i.ready = room;
  assign in_acc     = in_i.valid && in_i.ready;

  // pending store, only row PendRow of its PendDepth rows is used
  jtn_ram #(
    .Width (2*CpW),
    .Depth (PendDepth)
  ) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (PendRow),
    .wdata_i ({step.pend1, step.pend0}),
    .raddr_i (PendRow),
    .rdata_o (ram_rdata)
  );

  // forward the row written last cycle, the ram read still shows old data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q      <= 1'b0;
      pend_cnt_q <= 2'd0;
    end else begin
      fwd_q <= in_acc;
      if (in_acc) begin
        pend_cnt_q <= step.pend_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_data_q <= {step.pend1, step.pend0};
    end
  end

  assign pend_row = fwd_q ? fwd_data_q : ram_rdata;
  assign pend0    = pend_row[CpW-1:0];
  assign pend1    = pend_row[2*CpW-1:CpW];

  // classify and fold
  jtn_step u_step (
    .pend_n_i (pend_cnt_q),
    .pend0_i  (pend0),
    .cp_i     (in_i.code_point),
    .fin_i    (in_i.last_char),
    .step_o   (step)
  );

  // result queue
  jtn_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (in_acc ? step.res_n : 2'd0),
    .res0_i   (step.res0),
    .res1_i   (step.res1),
    .room_o   (room),
    .out_o    (out_o)
  );

`ifndef SYNTH
  // end of string leaves nothing pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.last_char |=> pend_cnt_q == 2'd0)
    else $error("pending characters left after end of string");

  // two pending characters are always halfwidth u and a voiced mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_cnt_q == 2'd2 |-> (pend0 == HkU) && (pend1 == MarkV))
    else $error("pending row does not match two-character lookahead");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_cnt_q != 2'd3)
    else $error("pending count out of range");

  // input stalls only when results are waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with empty result queue");
`endif

endmodule

### hdl/jtn_ram.sv
module jtn_ram #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on a same-cycle write
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/jtn_step.sv
module jtn_step import jtn_pkg::*; (
  input  logic [1:0] pend_n_i,
  input  cp_t        pend0_i,
  input  cp_t        cp_i,
  input  logic       fin_i,
  output step_t      step_o
);

  cp_t  pre_v;
  logic pre_ok;
  logic c_used;
  logic c_ok;
  cp_t  c_v;

  // resolve the pending characters against the new one
  always_comb begin
    pre_v  = cp_i;
    pre_ok = 1'b0;
    c_used = 1'b0;
    step_o.pend_n = 2'd0;
    step_o.pend0  = cp_i;
    step_o.pend1  = cp_i;
    case (pend_n_i)
      2'd1: begin
        if ((pend0_i == HkU) && (cp_i == MarkV)) begin
          c_used = 1'b1;
          if (fin_i) begin
            pre_ok = 1'b1;
            pre_v  = 21'h030D6;
          end else begin
            step_o.pend_n = 2'd2;
            step_o.pend0  = pend0_i;
            step_o.pend1  = cp_i;
          end
        end else begin
          pre_ok = 1'b1;
          if (pend0_i == VuFull) begin
            c_used = 1'b1;
            case (cp_i)
              21'h030A1: pre_v = 21'h030D0;
              21'h030A3: pre_v = 21'h030D3;
              21'h030A7: pre_v = 21'h030D9;
              21'h030A9: pre_v = 21'h030DC;
              default: begin
                pre_v  = 21'h030D6;
                c_used = 1'b0;
              end
            endcase
          end else if (pend0_i == HkU) begin
            pre_v = 21'h030A6;
          end else if ((cp_i == MarkV) || (cp_i == MarkSv)) begin
            pre_v  = hk_marked(pend0_i, cp_i);
            c_used = 1'b1;
          end else begin
            pre_v = hk_plain(pend0_i);
          end
        end
      end
      2'd2: begin
        pre_ok = 1'b1;
        c_used = 1'b1;
        case (cp_i)
          21'h0FF67: pre_v = 21'h030D0;
          21'h0FF68: pre_v = 21'h030D3;
          21'h0FF6A: pre_v = 21'h030D9;
          21'h0FF6B: pre_v = 21'h030DC;
          default: begin
            pre_v  = 21'h030D6;
            c_used = 1'b0;
          end
        endcase
      end
      default: begin
        pre_ok = 1'b0;
      end
    endcase

    // new character on its own, held back when it needs lookahead
    c_ok = 1'b0;
    c_v  = fold_one(cp_i);
    if (!c_used) begin
      if (is_holder(cp_i) && !fin_i) begin
        step_o.pend_n = 2'd1;
        step_o.pend0  = cp_i;
      end else begin
        c_ok = 1'b1;
      end
    end

    // pack results in order, end mark on the last one
    step_o.res_n     = {1'b0, pre_ok} + {1'b0, c_ok};
    step_o.res0.cp   = pre_ok ? pre_v : c_v;
    step_o.res0.last = fin_i && !(pre_ok && c_ok);
    step_o.res1.cp   = c_v;
    step_o.res1.last = fin_i;
  end

endmodule

### hdl/jtn_outq.sv
module jtn_outq import jtn_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [1:0]   push_n_i,
  input  res_t         res0_i,
  input  res_t         res1_i,
  output logic         room_o,
  jtn_out_if.source    out_o
);

  localparam int QDepth = 4;

  res_t       ent_q [QDepth];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign pop    = out_o.valid && out_o.ready;
  assign room_o = cnt_q <= 3'd2;

  // pointers and fill level
  always_comb begin
    wr_d  = wr_q + push_n_i;
    rd_d  = rd_q + {1'b0, pop};
    cnt_d = cnt_q + {1'b0, push_n_i} - {2'd0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // result storage, up to two writes per cycle
  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      ent_q[wr_q] <= res0_i;
    end
    if (push_n_i == 2'd2) begin
      ent_q[wr_q + 2'd1] <= res1_i;
    end
  end

  assign out_o.valid          = cnt_q != 3'd0;
  assign out_o.out_code_point = ent_q[rd_q].cp;
  assign out_o.out_last       = ent_q[rd_q].last;

endmodule
